[src/bcntd_pkg.sv]
// Shared types, format codes and arithmetic helpers of the BCn block decoder.
`timescale 1ns / 1ps

package bcntd_pkg;

  // Block format codes held in the format register.
  typedef enum logic [1:0] {
    FMT_DXT1  = 2'd0,
    FMT_DXT3  = 2'd1,
    FMT_DXT5  = 2'd2,
    FMT_DXT5A = 2'd3
  } fmt_e;

  // Register index of the format register.
  localparam logic REG_FORMAT = 1'b0;

  // One palette entry.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // Expanded endpoints of one block, ready for palette interpolation.
  typedef struct packed {
    fmt_e        fmt;
    logic        three_col;
    rgba_t       c0;
    rgba_t       c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [63:0] lo;
    logic [31:0] cidx;
  } ep_t;

  // Full colour and alpha palettes of one block with its texel indices.
  typedef struct packed {
    fmt_e            fmt;
    rgba_t [3:0]     col;
    logic [7:0][7:0] alp;
    logic [63:0]     lo;
    logic [31:0]     cidx;
  } pal_t;

  // Truncating x/3 for x up to 765, by reciprocal multiplication.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // Truncating x/5 for x up to 1275.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

  // Truncating x/7 for x up to 1785.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // v*255/31 truncated: 8v plus floor(7v/31).
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  t;
    logic [15:0] p;
    t = 8'(v) * 8'd7;
    p = 16'(t) * 16'd265;
    return {v, 3'b000} + 8'(p[15:13]);
  endfunction

  // v*255/63 truncated: 4v plus floor(v/21).
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v == 6'd63);
    return {v, 2'b00} + 8'(q);
  endfunction

endpackage

[src/bcntd_palette.sv]
// Palette builder: interpolates colour and alpha palettes from expanded endpoints.
`timescale 1ns / 1ps

module bcntd_palette (
  input  bcntd_pkg::ep_t  ep_i,
  output bcntd_pkg::pal_t pal_o
);

  logic [7:0] p0 [3];
  logic [7:0] p1 [3];
  logic [7:0][7:0] alp;
  bcntd_pkg::rgba_t [3:0] col;

  // Endpoint channels as arrays for the per-channel interpolation.
  always_comb begin
    p0[0] = ep_i.c0.r;
    p0[1] = ep_i.c0.g;
    p0[2] = ep_i.c0.b;
    p1[0] = ep_i.c1.r;
    p1[1] = ep_i.c1.g;
    p1[2] = ep_i.c1.b;
  end

  // Colour palette: four-colour thirds, or halves plus transparent black.
  always_comb begin
    logic [7:0] m2 [3];
    logic [7:0] m3 [3];
    for (int ch = 0; ch < 3; ch++) begin
      if (ep_i.three_col) begin
        m2[ch] = 8'((9'(p0[ch]) + 9'(p1[ch])) >> 1);
        m3[ch] = 8'd0;
      end else begin
        m2[ch] = bcntd_pkg::div3(10'({p0[ch], 1'b0}) + 10'(p1[ch]));
        m3[ch] = bcntd_pkg::div3(10'(p0[ch]) + 10'({p1[ch], 1'b0}));
      end
    end
    col[0] = ep_i.c0;
    col[1] = ep_i.c1;
    col[2] = '{r: m2[0], g: m2[1], b: m2[2], a: 8'd255};
    col[3] = '{r: m3[0], g: m3[1], b: m3[2], a: (ep_i.three_col ? 8'd0 : 8'd255)};
  end

  // Alpha palette: eight entries with six interpolated, or six plus zero and full.
  always_comb begin
    alp[0] = ep_i.a0;
    alp[1] = ep_i.a1;
    if (ep_i.a0 > ep_i.a1) begin
      for (int k = 1; k < 7; k++) begin
        alp[k + 1] = bcntd_pkg::div7(11'(7 - k) * 11'(ep_i.a0) + 11'(k) * 11'(ep_i.a1));
      end
    end else begin
      for (int k = 1; k < 5; k++) begin
        alp[k + 1] = bcntd_pkg::div5(11'(5 - k) * 11'(ep_i.a0) + 11'(k) * 11'(ep_i.a1));
      end
      alp[6] = 8'd0;
      alp[7] = 8'd255;
    end
  end

  assign pal_o = '{fmt: ep_i.fmt, col: col, alp: alp, lo: ep_i.lo, cidx: ep_i.cidx};

endmodule

[src/bcn_texture_block_decoder_unit.sv]
// Top level of the BCn texture block decoder: block pipeline and texel emitter.
`timescale 1ns / 1ps

// Channel   | Signals                                   | Moves
// ----------+-------------------------------------------+-------------------------------
// input     | in_valid_i / in_ready_o                   | one compressed 4x4 block
// output    | out_valid_o / out_ready_i                 | one RGBA8 texel, last flagged
// config    | psel, penable, pwrite, paddr, pwdata      | block_format at address 0
//
// Each block yields sixteen texels, one per cycle when the output is not stalled;
// the single texel output register sets that rate.
// A block passes an input register, an endpoint register and a palette register
// before its texels stream out. The next block is taken while the current one is
// emitting; output stalls back up through the stages without losing data. Reset
// clears all valid flags and the format register (DXT1).

module bcn_texture_block_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Block input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  // Texel output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  texel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_texel_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bcntd_pkg::fmt_e  fmt_q;
  logic             s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic [63:0]      s0_lo_q, s0_hi_q;
  bcntd_pkg::fmt_e  s0_fmt_q;
  bcntd_pkg::ep_t   s1_q, s1_d;
  bcntd_pkg::pal_t  s2_q, s2_d;
  logic [3:0]       cnt_q;
  logic             in_fire, s0_move, s1_move, s1_free, s2_free, load, last_cnt;
  logic [3:0]       tex_idx_q;
  logic [7:0]       red_q, green_q, blue_q, alpha_q;
  logic             last_q;
  logic [7:0]       red_d, green_d, blue_d, alpha_d;

  // Configuration port: one register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bcntd_pkg::REG_FORMAT) ? {30'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= bcntd_pkg::FMT_DXT1;
    end else if (psel && penable && pwrite && pready && paddr[2] == bcntd_pkg::REG_FORMAT) begin
      fmt_q <= bcntd_pkg::fmt_e'(pwdata[1:0]);
    end
  end

  // Pipeline flow control: the palette register is freed when its last texel loads.
  assign last_cnt   = (cnt_q == 4'd15);
  assign load       = s2_v_q && (!out_v_q || out_ready_i);
  assign s2_free    = !s2_v_q || (load && last_cnt);
  assign s1_move    = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s1_move;
  assign s0_move    = s0_v_q && s1_free;
  assign in_ready_o = !s0_v_q || s0_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      if (in_fire) begin
        s0_v_q <= 1'b1;
      end else if (s0_move) begin
        s0_v_q <= 1'b0;
      end
      if (s0_move) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (load && last_cnt) begin
        s2_v_q <= 1'b0;
      end
      if (load) begin
        out_v_q <= 1'b1;
        cnt_q   <= cnt_q + 4'd1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Input register captures the request and the format in force.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_lo_q  <= block_low_i;
      s0_hi_q  <= block_high_i;
      s0_fmt_q <= fmt_q;
    end
  end

  // Endpoint stage: pick the colour half and expand the RGB565 endpoints.
  always_comb begin
    logic [63:0] cblk;
    logic [15:0] c0, c1;
    cblk = (s0_fmt_q == bcntd_pkg::FMT_DXT1) ? s0_lo_q : s0_hi_q;
    c0   = cblk[15:0];
    c1   = cblk[31:16];
    s1_d.fmt       = s0_fmt_q;
    s1_d.three_col = (s0_fmt_q == bcntd_pkg::FMT_DXT1) && !(c0 > c1);
    s1_d.c0        = '{r: bcntd_pkg::expand5(c0[15:11]), g: bcntd_pkg::expand6(c0[10:5]),
                       b: bcntd_pkg::expand5(c0[4:0]), a: 8'd255};
    s1_d.c1        = '{r: bcntd_pkg::expand5(c1[15:11]), g: bcntd_pkg::expand6(c1[10:5]),
                       b: bcntd_pkg::expand5(c1[4:0]), a: 8'd255};
    s1_d.a0        = s0_lo_q[7:0];
    s1_d.a1        = s0_lo_q[15:8];
    s1_d.lo        = s0_lo_q;
    s1_d.cidx      = cblk[63:32];
  end

  always_ff @(posedge clk_i) begin
    if (s0_move) begin
      s1_q <= s1_d;
    end
  end

  // Palette stage.
  bcntd_palette u_palette (
    .ep_i  (s1_q),
    .pal_o (s2_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_q <= s2_d;
    end
  end

  // Texel select: index the palettes for the texel under the counter.
  always_comb begin
    logic [1:0]       ci;
    logic [2:0]       ai;
    logic [3:0]       nib;
    logic [5:0]       abase;
    bcntd_pkg::rgba_t c;
    ci    = s2_q.cidx[{cnt_q, 1'b0} +: 2];
    abase = 6'd16 + 6'(cnt_q) * 6'd3;
    ai    = s2_q.lo[abase +: 3];
    nib   = s2_q.lo[{cnt_q, 2'b00} +: 4];
    c     = s2_q.col[ci];
    red_d   = c.r;
    green_d = c.g;
    blue_d  = c.b;
    alpha_d = c.a;
    case (s2_q.fmt)
      bcntd_pkg::FMT_DXT1: begin
        alpha_d = c.a;
      end
      bcntd_pkg::FMT_DXT3: begin
        alpha_d = {nib, nib};
      end
      bcntd_pkg::FMT_DXT5: begin
        alpha_d = s2_q.alp[ai];
      end
      bcntd_pkg::FMT_DXT5A: begin
        red_d   = s2_q.alp[ai];
        green_d = s2_q.alp[ai];
        blue_d  = s2_q.alp[ai];
        alpha_d = 8'd255;
      end
      default: begin
        alpha_d = c.a;
      end
    endcase
  end

  // Output register holds one texel until it is taken.
  always_ff @(posedge clk_i) begin
    if (load) begin
      tex_idx_q <= cnt_q;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      alpha_q   <= alpha_d;
      last_q    <= last_cnt;
    end
  end

  assign out_valid_o   = out_v_q;
  assign texel_index_o = tex_idx_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign alpha_o       = alpha_q;
  assign last_texel_o  = last_q;

endmodule

[dv/bcn_texture_block_decoder_unit_tb.sv]
// Self-checking testbench of the BCn texture block decoder unit.
`timescale 1ns / 1ps

module bcn_texture_block_decoder_unit_tb;

  // Index ramps: colour texel i uses i%4, alpha texel i uses i%8.
  localparam logic [31:0] COLOUR_RAMP = 32'hE4E4E4E4;
  localparam logic [47:0] ALPHA_RAMP  = 48'hFAC688FAC688;
  localparam logic [2:0]  ADDR_FORMAT = {bcntd_pkg::REG_FORMAT, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;
  localparam int          STALL_LIMIT = 2000;
  localparam logic [63:0] ONES        = {64{1'b1}};

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } texel_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [63:0] block_low_i  = '0;
  logic [63:0] block_high_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [3:0]  texel_index_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        last_texel_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Decoded texels still owed by the block, oldest first.
  texel_t expected_texels[$];
  texel_t want;
  bcntd_pkg::fmt_e cur_fmt = bcntd_pkg::FMT_DXT1;
  int     errors         = 0;
  int     blocks_sent    = 0;
  int     texels_seen    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     stuck_cycles   = 0;
  logic   hold_out       = 1'b0;

  bcn_texture_block_decoder_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .block_low_i(block_low_i),
    .block_high_i(block_high_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .texel_index_o(texel_index_o),
    .red_o(red_o),
    .green_o(green_o),
    .blue_o(blue_o),
    .alpha_o(alpha_o),
    .last_texel_o(last_texel_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one block into its sixteen texels and queue them.
  function automatic void predict_texels(input bcntd_pkg::fmt_e fmt, input logic [63:0] lo,
                                         input logic [63:0] hi);
    logic [63:0] cblk;
    int c0, c1, a0, a1, k, i, ch, ci, ai;
    int cp[4][4];
    int ap[8];
    texel_t t;
    cblk = (fmt == bcntd_pkg::FMT_DXT1) ? lo : hi;
    c0 = cblk[15:0];
    c1 = cblk[31:16];
    cp[0][0] = ((c0 >> 11) & 31) * 255 / 31;
    cp[0][1] = ((c0 >> 5) & 63) * 255 / 63;
    cp[0][2] = (c0 & 31) * 255 / 31;
    cp[1][0] = ((c1 >> 11) & 31) * 255 / 31;
    cp[1][1] = ((c1 >> 5) & 63) * 255 / 63;
    cp[1][2] = (c1 & 31) * 255 / 31;
    cp[0][3] = 255;
    cp[1][3] = 255;
    cp[2][3] = 255;
    // Only DXT1 falls back to three colours plus transparent black.
    if (c0 > c1 || fmt != bcntd_pkg::FMT_DXT1) begin
      for (ch = 0; ch < 3; ch++) begin
        cp[2][ch] = (2 * cp[0][ch] + cp[1][ch]) / 3;
        cp[3][ch] = (cp[0][ch] + 2 * cp[1][ch]) / 3;
      end
      cp[3][3] = 255;
    end else begin
      for (ch = 0; ch < 3; ch++) begin
        cp[2][ch] = (cp[0][ch] + cp[1][ch]) / 2;
        cp[3][ch] = 0;
      end
      cp[3][3] = 0;
    end
    // Interpolated alpha palette, eight or six entries.
    a0 = lo[7:0];
    a1 = lo[15:8];
    ap[0] = a0;
    ap[1] = a1;
    if (a0 > a1) begin
      for (k = 1; k < 7; k++) ap[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (k = 1; k < 5; k++) ap[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      ap[6] = 0;
      ap[7] = 255;
    end
    for (i = 0; i < 16; i++) begin
      ai = int'((lo >> (16 + 3 * i)) & 64'd7);
      ci = int'((cblk >> (32 + 2 * i)) & 64'd3);
      t.idx  = 4'(i);
      t.last = (i == 15);
      if (fmt == bcntd_pkg::FMT_DXT5A) begin
        t.r = 8'(ap[ai]);
        t.g = 8'(ap[ai]);
        t.b = 8'(ap[ai]);
        t.a = 8'd255;
      end else begin
        t.r = 8'(cp[ci][0]);
        t.g = 8'(cp[ci][1]);
        t.b = 8'(cp[ci][2]);
        if (fmt == bcntd_pkg::FMT_DXT3) begin
          t.a = 8'(int'((lo >> (4 * i)) & 64'd15) * 17);
        end else if (fmt == bcntd_pkg::FMT_DXT5) begin
          t.a = 8'(ap[ai]);
        end else begin
          t.a = 8'(cp[ci][3]);
        end
      end
      expected_texels = {expected_texels, t};
    end
  endfunction

  // Offer one block after a random gap and hold it until it is accepted.
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
    predict_texels(cur_fmt, lo, hi);
    blocks_sent++;
  endtask

  // Stop offering and wait until every queued texel has come out.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Setup then access phase; the model follows only writes to the format register.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == bcntd_pkg::REG_FORMAT) cur_fmt = bcntd_pkg::fmt_e'(data[1:0]);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Receiver: random stalls, or a forced hold-off while hold_out is set.
  always @(posedge clk_i) begin
    out_ready_i <= hold_out ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted texel with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      texels_seen++;
      if (expected_texels.size() == 0) begin
        errors++;
        $display("%0t: texel %0d with no block pending", $time, texel_index_o);
      end else begin
        want = expected_texels.pop_front();
        check_field("texel_index", want.idx, texel_index_o);
        check_field("red", want.r, red_o);
        check_field("green", want.g, green_o);
        check_field("blue", want.b, blue_o);
        check_field("alpha", want.a, alpha_o);
        check_field("last_texel", want.last, last_texel_o);
      end
    end
  end

  // Watchdog on cycles without any request moving.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // DXT1: opaque four-colour mode, three-colour mode with transparent black.
  task automatic test_dxt1_modes;
    drain();
    reg_write(ADDR_FORMAT, 32'(bcntd_pkg::FMT_DXT1));
    send_block(64'd0, ONES);
    send_block(ONES, 64'd0);
    send_block({COLOUR_RAMP, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
    send_block({COLOUR_RAMP, 16'hFFFF, 16'h0000}, ONES);
    send_block({32'h1B1B1B1B, 16'h07E0, 16'hF800}, {$urandom, $urandom});
  endtask

  // DXT2/3: nibble alpha; colour is always four-colour even with c0 <= c1.
  // The format value carries set upper bits that must be dropped.
  task automatic test_explicit_alpha;
    drain();
    reg_write(ADDR_FORMAT, {30'h3FFFFFFF, bcntd_pkg::FMT_DXT3});
    send_block(64'hFEDCBA9876543210, {COLOUR_RAMP, 16'hFFFF, 16'h0000});
    send_block(64'd0, ONES);
    send_block(ONES, 64'd0);
  endtask

  // DXT4/5: eight-entry, six-entry and equal-endpoint alpha palettes.
  task automatic test_interpolated_alpha;
    drain();
    reg_write(ADDR_FORMAT, 32'(bcntd_pkg::FMT_DXT5));
    send_block({ALPHA_RAMP, 8'd0, 8'd255}, {COLOUR_RAMP, 16'h001F, 16'hF800});
    send_block({ALPHA_RAMP, 8'd255, 8'd0}, {COLOUR_RAMP, 16'hF800, 16'h001F});
    send_block({ALPHA_RAMP, 8'h80, 8'h80}, {$urandom, $urandom});
    send_block(ONES, ONES);
  endtask

  // DXT5A: alpha replicated into RGB, high half ignored.
  task automatic test_alpha_only;
    drain();
    reg_write(ADDR_FORMAT, 32'(bcntd_pkg::FMT_DXT5A));
    send_block({ALPHA_RAMP, 8'd10, 8'd200}, ONES);
    send_block({ALPHA_RAMP, 8'd200, 8'd10}, 64'd0);
    send_block(64'd0, ONES);
  endtask

  // A write to an unused register index must leave the format alone.
  task automatic test_register_decode;
    drain();
    reg_write(ADDR_UNUSED, 32'(bcntd_pkg::FMT_DXT1));
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({ALPHA_RAMP, 16'h00FF}, ONES);
    drain();
    reg_write(ADDR_FORMAT, 32'(bcntd_pkg::FMT_DXT1));
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Hold the output off long enough that the block backs up into its input.
  task automatic test_output_backpressure;
    int n;
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reg_write(ADDR_FORMAT, 32'(bcntd_pkg::FMT_DXT5));
    hold_out <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_out <= 1'b0;
      end
    join_none
    for (n = 0; n < 10; n++) send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Random blocks in every format under each idle mix.
  task automatic test_random_blocks;
    int send_mix[4];
    int recv_mix[4];
    int p, f, n;
    logic [63:0] lo, hi;
    logic [31:0] wdata;
    send_mix = '{0, 58, 0, 9};
    recv_mix = '{0, 0, 58, 9};
    for (p = 0; p < 4; p++) begin
      for (f = 0; f < 4; f++) begin
        drain();
        send_idle_pct  = send_mix[p];
        recv_stall_pct = recv_mix[p];
        wdata = $urandom;
        wdata[1:0] = 2'(f);
        reg_write(ADDR_FORMAT, wdata);
        for (n = 0; n < 6; n++) begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          // Now and then force equal endpoints to hit the boundary of the mode choice.
          case ($urandom_range(7))
            0: lo[31:16] = lo[15:0];
            1: lo[15:8] = lo[7:0];
            2: hi[31:16] = hi[15:0];
            default: ;
          endcase
          send_block(lo, hi);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dxt1_modes();
    test_explicit_alpha();
    test_interpolated_alpha();
    test_alpha_only();
    test_register_decode();
    test_output_backpressure();
    test_random_blocks();
    drain();
    repeat (20) @(posedge clk_i);
    $display("Decoded %0d blocks (%0d texels) in all four formats under four idle mixes",
             blocks_sent, texels_seen);
    $display("and one long output hold-off; %0d mismatches found.", errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/bcntd_pkg.sv
src/bcntd_palette.sv
src/bcn_texture_block_decoder_unit.sv
dv/bcn_texture_block_decoder_unit_tb.sv
